// ----- hw/rtl/sobel_pkg.sv -----
// Package: shared types, constants and the Sobel gradient helpers.
package sobel_pkg;

  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 4096;
  localparam int ColW      = 11;
  localparam int RowW      = 13;
  localparam int PixW      = 24;
  localparam int QDepth    = 4;
  localparam int QPtrW     = 2;

  localparam logic [0:0] RegFrameWidth  = 1'b0;
  localparam logic [0:0] RegFrameHeight = 1'b1;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic       is_flush;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last_of_frame;
  } out_item_t;

  // One classified window: neighbourhood already masked at the image border.
  typedef struct packed {
    logic [8:0][PixW-1:0] nb;
    logic                 last;
  } job_t;

  typedef struct packed {
    logic [17:0] gx2;
    logic [17:0] gy2;
  } sq_t;

  // Signed gradient of one channel, kernel selected by is_y.
  function automatic logic signed [11:0] grad(input logic [8:0][7:0] v, input logic is_y);
    logic signed [11:0] g;
    if (is_y)
      g = -$signed({4'd0, v[0]}) - ($signed({4'd0, v[1]}) <<< 1) - $signed({4'd0, v[2]})
          + $signed({4'd0, v[6]}) + ($signed({4'd0, v[7]}) <<< 1) + $signed({4'd0, v[8]});
    else
      g = -$signed({4'd0, v[0]}) + $signed({4'd0, v[2]}) - ($signed({4'd0, v[3]}) <<< 1)
          + ($signed({4'd0, v[5]}) <<< 1) - $signed({4'd0, v[6]}) + $signed({4'd0, v[8]});
    return g;
  endfunction

  function automatic logic [10:0] absv(input logic signed [11:0] g);
    logic [11:0] a;
    a = g[11] ? 12'(-g) : 12'(g);
    return a[10:0];
  endfunction

endpackage

// ----- hw/rtl/sobel_edge_magnitude_rgb.sv -----
// Sobel edge magnitude on an RGB raster stream: top level.
// Input channel in_valid/in_stall carries one pixel (or a flush marker) per
// transaction in raster order. After frame_width*frame_height pixels,
// frame_width+1 flush transactions drain the last row; the last result of a
// frame has last_of_frame set. Results appear on out_valid/out_stall, lagging
// input by one row plus one pixel, one result per input from that point on.
// Each input passes the front-end states in turn (accept, line-buffer read,
// window update), and no new input is accepted until the window update is
// done. The back end works through one result at a time (pop, three
// channels of gradient, square and an 8-step square root plus rounding,
// then the output register; a saturated channel skips its root), and is
// the limit when results are produced; a 4-entry queue parts the two ends.
// Configuration writes (cfg_we, cfg_idx, cfg_data) restart the frame.
// Reset (rst, synchronous) clears position, window, queue and output valid
// and sets the size to 640 by 480; line buffers need no clearing.
// While out_stall is high the result register holds and the back end waits;
// the queue fills and then in_stall rises.
module sobel_edge_magnitude_rgb (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_idx,
  input  logic [12:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sobel_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sobel_pkg::out_item_t out_item
);
  logic job_valid, q_full, q_empty, q_pop;
  sobel_pkg::job_t job, head;

  sobel_front u_front (.clk, .rst, .cfg_we, .cfg_idx, .cfg_data, .in_valid, .in_stall,
    .in_item, .job_valid, .job, .q_full);
  sobel_queue u_queue (.clk, .rst, .push(job_valid), .push_data(job), .pop(q_pop),
    .empty(q_empty), .full(q_full), .head);
  sobel_back u_back (.clk, .rst, .q_empty, .q_head(head), .q_pop, .out_valid, .out_stall,
    .out_item);

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> !q_full) else $error("accept while full");
`endif
endmodule

// ----- hw/rtl/sobel_ram.sv -----
// Generic single-port-write, registered-read RAM.
module sobel_ram #(
  parameter int Width = 24,
  parameter int Depth = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/sobel_front.sv -----
// Front end: raster position, line buffers, window and border masking.
module sobel_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_idx,
  input  logic [12:0]              cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  sobel_pkg::in_item_t      in_item,
  output logic                     job_valid,
  output sobel_pkg::job_t          job,
  input  logic                     q_full
);
  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SRead = 2'd1;
  localparam logic [1:0] SExec = 2'd2;

  logic [11:0] frame_width;
  logic [12:0] frame_height;
  logic [11:0] w_eff;
  logic [12:0] h_eff;
  logic [sobel_pkg::ColW-1:0] col;
  logic [sobel_pkg::RowW-1:0] row;
  logic pending;
  logic [1:0] state;
  logic [sobel_pkg::PixW-1:0] pix;
  logic [8:0][sobel_pkg::PixW-1:0] win, win_next, nb;
  logic [sobel_pkg::PixW-1:0] older_q, newer_q;
  logic emit, last_col, is_end;
  logic [sobel_pkg::RowW:0] cr, cc;
  logic [sobel_pkg::PixW-1:0] p_new;

  always_comb begin
    w_eff = (frame_width == '0) ? 12'd1 :
            (frame_width > 12'(sobel_pkg::MaxWidth)) ? 12'(sobel_pkg::MaxWidth) : frame_width;
    h_eff = (frame_height == '0) ? 13'd1 :
            (frame_height > 13'(sobel_pkg::MaxHeight)) ? 13'(sobel_pkg::MaxHeight) :
            frame_height;
  end

  assign in_stall = (state != SIdle) || q_full;

  sobel_ram #(.Width(sobel_pkg::PixW), .Depth(sobel_pkg::MaxWidth)) u_older (
    .clk, .we(state == SExec), .waddr(col), .wdata(newer_q), .raddr(col), .rdata(older_q));
  sobel_ram #(.Width(sobel_pkg::PixW), .Depth(sobel_pkg::MaxWidth)) u_newer (
    .clk, .we(state == SExec), .waddr(col), .wdata(p_new), .raddr(col), .rdata(newer_q));

  assign p_new  = pix;
  assign emit   = pending || (row >= 13'd2) || (row == 13'd1 && col != '0);
  assign is_end = {1'b0, row} >= {1'b0, h_eff} + 14'd1;
  assign last_col = {1'b0, col} + 12'd1 >= w_eff;

  always_comb begin
    win_next = win;
    for (int k = 0; k < 3; k++) begin
      win_next[k*3+0] = win[k*3+1];
      win_next[k*3+1] = win[k*3+2];
    end
    win_next[2] = older_q;
    win_next[5] = newer_q;
    win_next[8] = pix;
    if (col == '0) begin
      for (int k = 0; k < 3; k++) begin
        nb[k*3+0] = win[k*3+1];
        nb[k*3+1] = win[k*3+2];
        nb[k*3+2] = '0;
      end
      cr = {1'b0, row} - 14'd2;
      cc = 14'({2'b0, w_eff} - 14'd1);
    end else begin
      nb = win_next;
      cr = {1'b0, row} - 14'd1;
      cc = {3'b0, col} - 14'd1;
    end
    if (cc == '0) begin nb[0] = '0; nb[3] = '0; nb[6] = '0; end
    if (cc + 14'd1 >= {2'b0, w_eff}) begin nb[2] = '0; nb[5] = '0; nb[8] = '0; end
    if (cr == '0) begin nb[0] = '0; nb[1] = '0; nb[2] = '0; end
    if (cr + 14'd1 >= {1'b0, h_eff}) begin nb[6] = '0; nb[7] = '0; nb[8] = '0; end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 12'd640;
      frame_height <= 13'd480;
      col <= '0; row <= '0; pending <= 1'b0; state <= SIdle;
      win <= '0; job_valid <= 1'b0;
    end else begin
      job_valid <= !cfg_we && (state == SExec) && emit;
      if (cfg_we) begin
        unique case (cfg_idx)
          sobel_pkg::RegFrameWidth:  frame_width  <= cfg_data[11:0];
          sobel_pkg::RegFrameHeight: frame_height <= cfg_data;
          default: ;
        endcase
        col <= '0; row <= '0; pending <= 1'b0; win <= '0; state <= SIdle;
      end else begin
        unique case (state)
          SIdle: if (in_valid && !q_full) begin
            pix <= (row < h_eff && !in_item.is_flush) ?
                   {in_item.in_red, in_item.in_green, in_item.in_blue} : '0;
            state <= SRead;
          end
          SRead: state <= SExec;
          SExec: begin
            state <= SIdle;
            win <= win_next;
            pending <= !is_end && (pending || emit);
            if (emit) begin
              job.nb    <= nb;
              job.last  <= is_end;
            end
            if (is_end) begin
              col <= '0; row <= '0;
            end else if (last_col) begin
              col <= '0; row <= row + 13'd1;
            end else begin
              col <= col + 11'd1;
            end
          end
          default: state <= SIdle;
        endcase
      end
    end
  end

`ifndef SYNTH
  a_job_from_exec: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> $past(state) == SExec) else $error("job without exec");
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == SRead || cfg_we || $past(cfg_we))
    else $error("accept did not start read");
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, col} < w_eff || cfg_we || $past(cfg_we)) else $error("column out of range");
`endif
endmodule

// ----- hw/rtl/sobel_queue.sv -----
// Small FIFO between classification and magnitude calculation.
module sobel_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sobel_pkg::job_t push_data,
  input  logic            pop,
  output logic            empty,
  output logic            full,
  output sobel_pkg::job_t head
);
  sobel_pkg::job_t mem [sobel_pkg::QDepth];
  logic [sobel_pkg::QPtrW-1:0] wp, rp;
  logic [sobel_pkg::QPtrW:0] cnt;

  assign empty = cnt == '0;
  // keep one slot back for the job already in flight in the front end
  assign full  = cnt >= 3'(sobel_pkg::QDepth - 1);
  assign head  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      cnt <= cnt + 3'(push) - 3'(pop);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && cnt == 3'(sobel_pkg::QDepth))) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty)) else $error("queue underflow");
`endif
endmodule

// ----- hw/rtl/sobel_back.sv -----
// Back end: gradients, squares, rounded square root, output register.
module sobel_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  sobel_pkg::job_t  q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output sobel_pkg::out_item_t out_item
);
  localparam logic [2:0] BIdle = 3'd0;
  localparam logic [2:0] BGrad = 3'd1;
  localparam logic [2:0] BSq   = 3'd2;
  localparam logic [2:0] BRoot = 3'd3;
  localparam logic [2:0] BOut  = 3'd4;

  logic [2:0] state;
  sobel_pkg::job_t job;
  logic [1:0] ch;
  logic [10:0] ax, ay;
  logic [20:0] s;
  logic [7:0] r;
  logic [3:0] bitn;
  logic [2:0][7:0] res;
  logic [8:0][7:0] v;
  logic [7:0] t;
  logic [15:0] tt;
  logic [4:0] sh;

  always_comb begin
    sh = 5'd16 - {ch, 3'd0};
    for (int k = 0; k < 9; k++) v[k] = 8'(job.nb[k] >> sh);
    t  = r | (8'd1 << bitn[2:0]);
    tt = t * t;
  end

  assign q_pop = (state == BIdle) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BIdle; out_valid <= 1'b0;
    end else begin
      unique case (state)
        BIdle: if (!q_empty) begin
          job <= q_head; ch <= '0; state <= BGrad;
        end
        BGrad: begin
          ax <= sobel_pkg::absv(sobel_pkg::grad(v, 1'b0));
          ay <= sobel_pkg::absv(sobel_pkg::grad(v, 1'b1));
          state <= BSq;
        end
        BSq: begin
          s <= 21'(ax * ax) + 21'(ay * ay);
          r <= '0; bitn <= 4'd7; state <= BRoot;
        end
        BRoot: begin
          if (s > 21'd65280) begin
            res[ch] <= 8'd255;
            bitn <= 4'd8;
          end else if (bitn == 4'd8) begin
            res[ch] <= (s > {5'b0, 16'(r * r)} + 21'(r)) ? r + 8'd1 : r;
          end else if ({5'b0, tt} <= s) begin
            r <= t;
          end
          if (s > 21'd65280 || bitn == 4'd8) begin
            if (ch == 2'd2) state <= BOut;
            else begin ch <= ch + 2'd1; state <= BGrad; end
          end else if (bitn == 4'd0) begin
            bitn <= 4'd8;
          end else begin
            bitn <= bitn - 4'd1;
          end
        end
        BOut: if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
          out_item  <= '{out_red: res[0], out_green: res[1], out_blue: res[2],
                         last_of_frame: job.last};
          state <= BIdle;
        end
        default: state <= BIdle;
      endcase
      if (out_valid && !out_stall && !(state == BOut)) out_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == BGrad) else $error("pop not followed by work");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(out_item)) else $error("held result lost");
`endif
endmodule

// ----- tb/sobel_edge_magnitude_rgb_tb.sv -----
// Testbench for the RGB Sobel edge magnitude block: random frames checked against an in-bench predictor.
`timescale 1ns / 100ps

module sobel_edge_magnitude_rgb_tb;
  import sobel_pkg::*;

  localparam int Limit     = 4_000_000;
  localparam int DrainWait = 120;

  class edge_scoreboard;
    logic [11:0] width_reg;
    logic [12:0] height_reg;
    bit [23:0]   older_row [MaxWidth];
    bit [23:0]   newer_row [MaxWidth];
    bit [23:0]   win [9];
    int          col, row;
    bit          started;
    out_item_t   expected_pixels [$];
    int          errors;

    function new();
      width_reg  = 12'd640;
      height_reg = 13'd480;
      errors     = 0;
      restart();
    endfunction

    function void restart();
      foreach (win[k]) win[k] = '0;
      col = 0;
      row = 0;
      started = 0;
    endfunction

    function int eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MaxWidth) return MaxWidth;
      return width_reg;
    endfunction

    function int eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > MaxHeight) return MaxHeight;
      return height_reg;
    endfunction

    function void set_register(logic [0:0] idx, logic [12:0] data);
      if (idx == RegFrameWidth) width_reg = data[11:0];
      else height_reg = data;
      restart();
    endfunction

    // rounded integer square root, clamped to 255
    function logic [7:0] magnitude(int gx, int gy);
      int s, r, t;
      s = gx * gx + gy * gy;
      if (s > 65280) return 8'd255;
      r = 0;
      for (int b = 128; b != 0; b = b >> 1) begin
        t = r | b;
        if (t * t <= s) r = t;
      end
      if (s > r * r + r) r++;
      return r[7:0];
    endfunction

    function void note_pixel(in_item_t it);
      int w, h, c, r, idx, cr, cc, gx, gy;
      bit [23:0] p;
      bit [23:0] col_new [3];
      bit [23:0] nb [9];
      int v [9];
      bit emit;
      logic [7:0] mag [3];
      out_item_t e;
      w = eff_width();
      h = eff_height();
      c = col;
      r = row;
      idx = c % MaxWidth;
      emit = started || r >= 2 || (r == 1 && c >= 1);
      p = (r < h && !it.is_flush) ? {it.in_red, it.in_green, it.in_blue} : 24'd0;
      col_new[0] = older_row[idx];
      col_new[1] = newer_row[idx];
      col_new[2] = p;
      older_row[idx] = newer_row[idx];
      newer_row[idx] = p;
      cr = 0;
      cc = 0;
      // column 0: centre is the end of row r-2, window taken before the shift
      if (emit && c == 0) begin
        cr = r - 2;
        cc = w - 1;
        for (int k = 0; k < 3; k++) begin
          nb[k*3]   = win[k*3+1];
          nb[k*3+1] = win[k*3+2];
          nb[k*3+2] = '0;
        end
      end
      for (int k = 0; k < 3; k++) begin
        win[k*3]   = win[k*3+1];
        win[k*3+1] = win[k*3+2];
        win[k*3+2] = col_new[k];
      end
      if (emit && c != 0) begin
        cr = r - 1;
        cc = c - 1;
        nb = win;
      end
      if (emit) begin
        if (cc < 1) begin nb[0] = '0; nb[3] = '0; nb[6] = '0; end
        if (cc + 1 >= w) begin nb[2] = '0; nb[5] = '0; nb[8] = '0; end
        if (cr < 1) begin nb[0] = '0; nb[1] = '0; nb[2] = '0; end
        if (cr + 1 >= h) begin nb[6] = '0; nb[7] = '0; nb[8] = '0; end
        for (int ch = 0; ch < 3; ch++) begin
          for (int k = 0; k < 9; k++) v[k] = (nb[k] >> (16 - 8 * ch)) & 8'hFF;
          gx = -v[0] + v[2] - 2 * v[3] + 2 * v[5] - v[6] + v[8];
          gy = -v[0] - 2 * v[1] - v[2] + v[6] + 2 * v[7] + v[8];
          mag[ch] = magnitude(gx, gy);
        end
        e.out_red = mag[0];
        e.out_green = mag[1];
        e.out_blue = mag[2];
        e.last_of_frame = (r >= h + 1);
        expected_pixels.push_back(e);
        started = 1;
      end
      if (r >= h + 1) begin
        col = 0;
        row = 0;
        started = 0;
      end else if (c + 1 >= w) begin
        col = 0;
        row = r + 1;
      end else begin
        col = c + 1;
      end
    endfunction

    task report(string what);
      $display("MISMATCH: %s", what);
      errors++;
    endtask

    task check_pixel(out_item_t got);
      out_item_t e;
      if (expected_pixels.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      e = expected_pixels.pop_front();
      if (got.out_red !== e.out_red)
        report($sformatf("red got %0d want %0d", got.out_red, e.out_red));
      if (got.out_green !== e.out_green)
        report($sformatf("green got %0d want %0d", got.out_green, e.out_green));
      if (got.out_blue !== e.out_blue)
        report($sformatf("blue got %0d want %0d", got.out_blue, e.out_blue));
      if (got.last_of_frame !== e.last_of_frame)
        report($sformatf("last_of_frame got %0b want %0b", got.last_of_frame,
                         e.last_of_frame));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [0:0]  cfg_idx;
  logic [12:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;

  edge_scoreboard sb = new();
  int  hold_cycles = 0;
  bit  tx_quiet = 0;
  bit  rx_quiet = 0;
  int  pixels_sent = 0;
  int  cycles = 0;

  sobel_edge_magnitude_rgb u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > Limit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // result side: random stalls, plus the long hold-off when requested
  initial begin
    int wait_left;
    wait_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        sb.check_pixel(out_item);
        wait_left = rx_quiet ? 0 : $urandom_range(0, 18);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task send_pixel(in_item_t it);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(it);
    pixels_sent++;
  endtask

  // only once every result is back and the front end has gone quiet
  task settle();
    in_valid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task write_reg(logic [0:0] idx, logic [12:0] data);
    settle();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, data);
  endtask

  function in_item_t rand_pixel(bit flush);
    in_item_t it;
    int pick;
    pick = $urandom_range(0, 9);
    it.in_red   = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
    it.in_green = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
    it.in_blue  = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
    it.is_flush = flush;
    return it;
  endfunction

  // sends a frame of the current size, drain included; stop_at < 0 means whole frame
  task send_frame(int noise, int stop_at);
    int total, img;
    img = sb.eff_width() * sb.eff_height();
    total = img + sb.eff_width() + 1;
    for (int n = 0; n < total; n++) begin
      if (n == stop_at) return;
      if (n < img) send_pixel(rand_pixel($urandom_range(0, 99) < noise));
      else send_pixel(rand_pixel(!($urandom_range(0, 99) < noise)));
    end
  endtask

  initial begin
    in_item_t it;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = RegFrameWidth;
    cfg_data = '0;
    in_valid = 1'b0;
    in_item = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 3x2 frame: black and white pixels, flush inside the image, pixel in the drain
    write_reg(RegFrameWidth, 13'd3);
    write_reg(RegFrameHeight, 13'd2);
    for (int n = 0; n < 10; n++) begin
      it.in_red = (n % 2) ? 8'd255 : 8'd0;
      it.in_green = (n % 3) ? 8'd255 : 8'd0;
      it.in_blue = (n < 3) ? 8'd255 : 8'd0;
      it.is_flush = (n == 4) || (n >= 6 && n != 8);
      send_pixel(it);
    end
    // zero sizes act as one pixel
    write_reg(RegFrameWidth, 13'd0);
    write_reg(RegFrameHeight, 13'd0);
    send_frame(20, -1);
    // widest row, single line: first part only
    write_reg(RegFrameWidth, 13'h0FFF);
    write_reg(RegFrameHeight, 13'd1);
    send_frame(2, 120);
    // tallest column, one pixel wide: first part only
    write_reg(RegFrameWidth, 13'd1);
    write_reg(RegFrameHeight, 13'h1FFF);
    send_frame(2, 120);

    for (int f = 0; pixels_sent < 600; f++) begin
      case ($urandom_range(0, 3))
        0: write_reg(RegFrameHeight, 13'($urandom_range(0, 6)));
        1: write_reg(RegFrameWidth, 13'($urandom_range(0, 9)));
        default: begin
          write_reg(RegFrameWidth, ($urandom_range(0, 9) == 0) ? 13'($urandom_range(12, 40))
                                                              : 13'($urandom_range(1, 8)));
          write_reg(RegFrameHeight, 13'($urandom_range(1, 6)));
        end
      endcase
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if (f == 5 || f == 30) begin
        // long receiver hold-off while the sender keeps going: fills the block
        tx_quiet = 1;
        hold_cycles = 500;
        sb.set_register(RegFrameWidth, 13'd12);
        sb.set_register(RegFrameHeight, 13'd6);
        write_reg(RegFrameWidth, 13'd12);
        write_reg(RegFrameHeight, 13'd6);
        hold_cycles = 500;
      end
      if ($urandom_range(0, 9) == 0) send_frame(5, $urandom_range(1, 20));
      else send_frame(($urandom_range(0, 3) == 0) ? 15 : 0, -1);
    end

    settle();
    if (sb.expected_pixels.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_pixels.size()));
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
